FILE: design/nrmc_pkg.sv
`default_nettype none
package nrmc_pkg;

	localparam int DEFAULT_LAT_CHARS = 11;
	localparam int DEFAULT_LON_CHARS = 12;

	localparam logic [39:0] TAG_RESET = 40'h474E524D43; // "GNRMC"

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_COMMA  = 8'h2C;

	// byte counter inside tag or field; holds up to the longest field length
	localparam int CNT_W = 5;

	// parse phases, also the microcode address
	localparam int PHASE_W = 4;
	localparam logic [PHASE_W-1:0] PH_HUNT   = 4'd0;
	localparam logic [PHASE_W-1:0] PH_TAG    = 4'd1;
	localparam logic [PHASE_W-1:0] PH_TIME   = 4'd2;
	localparam logic [PHASE_W-1:0] PH_STATUS = 4'd3;
	localparam logic [PHASE_W-1:0] PH_LAT    = 4'd4;
	localparam logic [PHASE_W-1:0] PH_NS     = 4'd5;
	localparam logic [PHASE_W-1:0] PH_LON    = 4'd6;
	localparam logic [PHASE_W-1:0] PH_EW     = 4'd7;
	localparam logic [PHASE_W-1:0] PH_SPEED  = 4'd8;
	localparam logic [PHASE_W-1:0] PH_COURSE = 4'd9;
	localparam logic [PHASE_W-1:0] PH_DATE   = 4'd10;
	localparam logic [PHASE_W-1:0] PH_MAGVAR = 4'd11;
	localparam logic [PHASE_W-1:0] PH_MAGDIR = 4'd12;
	localparam logic [PHASE_W-1:0] PH_MODE   = 4'd13;

	// microcode operations
	localparam logic [1:0] OP_HUNT  = 2'd0;
	localparam logic [1:0] OP_TAG   = 2'd1;
	localparam logic [1:0] OP_FIELD = 2'd2;
	localparam logic [1:0] OP_BAD   = 2'd3;

	// capture targets
	localparam logic [2:0] CAP_NONE = 3'd0;
	localparam logic [2:0] CAP_LAT  = 3'd1;
	localparam logic [2:0] CAP_NS   = 3'd2;
	localparam logic [2:0] CAP_LON  = 3'd3;
	localparam logic [2:0] CAP_EW   = 3'd4;

	typedef struct packed {
		logic [1:0]       op;
		logic [CNT_W-1:0] len;
		logic [2:0]       cap;
		logic             emit;
	} uword_t;

	// sequencer -> datapath control
	typedef struct packed {
		logic [2:0]       cap;
		logic [CNT_W-1:0] cap_idx;
		logic             emit;
	} ctl_t;

	// control store: one word per phase
	function automatic uword_t ucode(input logic [PHASE_W-1:0] ph,
	                                 input logic [CNT_W-1:0] lat,
	                                 input logic [CNT_W-1:0] lon);
		uword_t w;
		w.op   = OP_FIELD;
		w.len  = '0;
		w.cap  = CAP_NONE;
		w.emit = 1'b0;
		case (ph)
			PH_HUNT:   w.op = OP_HUNT;
			PH_TAG:    w.op = OP_TAG;
			PH_TIME:   w.len = 5'd10;
			PH_STATUS: w.len = 5'd1;
			PH_LAT: begin
				w.len = lat;
				w.cap = CAP_LAT;
			end
			PH_NS: begin
				w.len = 5'd1;
				w.cap = CAP_NS;
			end
			PH_LON: begin
				w.len = lon;
				w.cap = CAP_LON;
			end
			PH_EW: begin
				w.len = 5'd1;
				w.cap = CAP_EW;
			end
			PH_SPEED:  w.len = 5'd5;
			PH_COURSE: w.len = 5'd7;
			PH_DATE:   w.len = 5'd6;
			PH_MAGVAR: w.len = 5'd0;
			PH_MAGDIR: w.len = 5'd1;
			PH_MODE:   w.emit = 1'b1;
			default:   w.op = OP_BAD;
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

FILE: design/nrmc_in_if.sv
`default_nettype none
interface nrmc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

FILE: design/nrmc_out_if.sv
`default_nettype none
interface nrmc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic [4:0] char_index;
	logic       last_char;

	modport source (output valid, output out_char, output char_index, output last_char,
		input ready);
	modport sink (input valid, input out_char, input char_index, input last_char,
		output ready);
endinterface
`default_nettype wire

FILE: design/nrmc_useq.sv
`default_nettype none
module nrmc_useq #(
	parameter int LAT_CHARS = nrmc_pkg::DEFAULT_LAT_CHARS,
	parameter int LON_CHARS = nrmc_pkg::DEFAULT_LON_CHARS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic [7:0]         rx_byte,
	input  wire logic [39:0]        tag,
	output nrmc_pkg::ctl_t          ctl
);
	logic [nrmc_pkg::PHASE_W-1:0] phase_q;
	logic [nrmc_pkg::CNT_W-1:0]   cnt_q;
	logic                         mis_q;
	logic                         cons_q;
	nrmc_pkg::uword_t             uw;
	logic [7:0]                   want;
	logic                         mis_n;
	logic [nrmc_pkg::CNT_W-1:0]   cnt_inc;
	logic                         is_comma;

	assign uw = nrmc_pkg::ucode(phase_q, nrmc_pkg::CNT_W'(LAT_CHARS),
		nrmc_pkg::CNT_W'(LON_CHARS));
	assign cnt_inc  = cnt_q + nrmc_pkg::CNT_W'(1);
	assign is_comma = (rx_byte == nrmc_pkg::CHAR_COMMA);

	// tag byte for this position, first byte in the top bits
	always_comb begin
		case (cnt_q[2:0])
			3'd0:    want = tag[39:32];
			3'd1:    want = tag[31:24];
			3'd2:    want = tag[23:16];
			3'd3:    want = tag[15:8];
			default: want = tag[7:0];
		endcase
	end
	assign mis_n = mis_q | (rx_byte != want);

	always_comb begin
		ctl.cap     = nrmc_pkg::CAP_NONE;
		ctl.cap_idx = cnt_q;
		ctl.emit    = 1'b0;
		if (step && uw.op == nrmc_pkg::OP_FIELD) begin
			if (cons_q)
				ctl.cap = uw.cap;
			else
				ctl.emit = is_comma & uw.emit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= nrmc_pkg::PH_HUNT;
			cnt_q   <= '0;
			mis_q   <= 1'b0;
			cons_q  <= 1'b0;
		end else if (step) begin
			case (uw.op)
				nrmc_pkg::OP_HUNT: begin
					if (rx_byte == nrmc_pkg::CHAR_DOLLAR) begin
						phase_q <= nrmc_pkg::PH_TAG;
						cnt_q   <= '0;
						mis_q   <= 1'b0;
					end
				end
				nrmc_pkg::OP_TAG: begin
					if (cnt_q == nrmc_pkg::CNT_W'(4)) begin
						phase_q <= mis_n ? nrmc_pkg::PH_HUNT : nrmc_pkg::PH_TIME;
						cnt_q   <= '0;
						cons_q  <= 1'b0;
						mis_q   <= 1'b0;
					end else begin
						cnt_q <= cnt_inc;
						mis_q <= mis_n;
					end
				end
				nrmc_pkg::OP_FIELD: begin
					if (!cons_q) begin
						if (is_comma) begin
							cnt_q <= '0;
							if (uw.emit)
								phase_q <= nrmc_pkg::PH_HUNT;
							else if (uw.len == '0)
								phase_q <= phase_q + nrmc_pkg::PHASE_W'(1);
							else
								cons_q <= 1'b1;
						end
					end else if (cnt_inc >= uw.len) begin
						cons_q  <= 1'b0;
						cnt_q   <= '0;
						phase_q <= phase_q + nrmc_pkg::PHASE_W'(1);
					end else begin
						cnt_q <= cnt_inc;
					end
				end
				default: begin
					phase_q <= nrmc_pkg::PH_HUNT;
					cnt_q   <= '0;
					cons_q  <= 1'b0;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: design/nmea_rmc_position_extractor.sv
// Parsing: one received byte per cycle, rx.ready high while no record is being sent.
// Record: the comma that closes the eleventh RMC field starts a run of
// 2+LAT_CHARS+LON_CHARS items (25 by default), one per cycle when pos.ready stays high;
// that comma sets the busy flag, and the first item is then loaded into the output register.
// Input stalls for the run.
// Reset (arst_n low, asynchronous): hunting for '$', no record pending, tag = "GNRMC".
`default_nettype none
module nmea_rmc_position_extractor #(
	parameter int LAT_CHARS = nrmc_pkg::DEFAULT_LAT_CHARS,
	parameter int LON_CHARS = nrmc_pkg::DEFAULT_LON_CHARS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	nrmc_in_if.sink          rx,
	nrmc_out_if.source       pos,
	input  wire logic        cfg_we,
	input  wire logic [39:0] cfg_wdata
);
	localparam int TOTAL = 2 + LAT_CHARS + LON_CHARS;
	localparam int EC_W  = $clog2(TOTAL + 1);
	localparam int LA_W  = (LAT_CHARS > 1) ? $clog2(LAT_CHARS) : 1;
	localparam int LO_W  = (LON_CHARS > 1) ? $clog2(LON_CHARS) : 1;

	// configured tag
	logic [39:0] tag_q;

	// captured fields
	logic [7:0] lat_q [LAT_CHARS];
	logic [7:0] lon_q [LON_CHARS];
	logic [7:0] ns_q;
	logic [7:0] ew_q;

	// record emission
	logic            emit_busy_q;
	logic [EC_W-1:0] emit_cnt_q;
	logic            out_valid_q;
	logic [7:0]      out_char_q;
	logic [4:0]      char_index_q;
	logic            last_char_q;

	logic            step;
	nrmc_pkg::ctl_t  ctl;
	logic            load;
	logic [EC_W-1:0] lat_off;
	logic [EC_W-1:0] lon_off;
	logic [7:0]      rd_char;
	logic            rd_last;

	// bytes are taken only while no record is being sent
	assign rx.ready = !emit_busy_q;
	assign step     = rx.valid & rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_q <= nrmc_pkg::TAG_RESET;
		else if (cfg_we)
			tag_q <= cfg_wdata;
	end

	// microcoded field walker: one control word per parse phase
	nrmc_useq #(
		.LAT_CHARS(LAT_CHARS),
		.LON_CHARS(LON_CHARS)
	) u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.rx_byte(rx.rx_byte),
		.tag    (tag_q),
		.ctl    (ctl)
	);

	// capture stores, written by the field walker
	always_ff @(posedge clk) begin
		case (ctl.cap)
			nrmc_pkg::CAP_LAT: lat_q[ctl.cap_idx[LA_W-1:0]] <= rx.rx_byte;
			nrmc_pkg::CAP_NS:  ns_q <= rx.rx_byte;
			nrmc_pkg::CAP_LON: lon_q[ctl.cap_idx[LO_W-1:0]] <= rx.rx_byte;
			nrmc_pkg::CAP_EW:  ew_q <= rx.rx_byte;
			default: ;
		endcase
	end

	// record order: N/S, latitude, E/W, longitude
	assign lat_off = emit_cnt_q - EC_W'(1);
	assign lon_off = emit_cnt_q - EC_W'(LAT_CHARS + 2);
	always_comb begin
		if (emit_cnt_q == '0)
			rd_char = ns_q;
		else if (emit_cnt_q <= EC_W'(LAT_CHARS))
			rd_char = lat_q[lat_off[LA_W-1:0]];
		else if (emit_cnt_q == EC_W'(LAT_CHARS + 1))
			rd_char = ew_q;
		else
			rd_char = lon_q[lon_off[LO_W-1:0]];
	end
	assign rd_last = (emit_cnt_q == EC_W'(TOTAL - 1));

	// next item goes into the output register when it is empty or being drained
	assign load = emit_busy_q & (!out_valid_q | pos.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_busy_q <= 1'b0;
			emit_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.emit) begin
				emit_busy_q <= 1'b1;
				emit_cnt_q  <= '0;
			end else if (load) begin
				emit_cnt_q <= emit_cnt_q + EC_W'(1);
				if (rd_last)
					emit_busy_q <= 1'b0;
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (pos.ready)
				out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q   <= rd_char;
			char_index_q <= 5'(emit_cnt_q);
			last_char_q  <= rd_last;
		end
	end

	assign pos.valid      = out_valid_q;
	assign pos.out_char   = out_char_q;
	assign pos.char_index = char_index_q;
	assign pos.last_char  = last_char_q;
endmodule
`default_nettype wire

FILE: dv/nmea_rmc_position_extractor_tb.sv
`timescale 1ns / 1ps
module nmea_rmc_position_extractor_tb;

	localparam int LAT = nrmc_pkg::DEFAULT_LAT_CHARS;
	localparam int LON = nrmc_pkg::DEFAULT_LON_CHARS;
	localparam int RECORD_CHARS = 2 + LAT + LON;
	localparam time CLK_PERIOD = 20ns;
	localparam int RESET_CYCLES = 7;
	// quiet time after the last record char before touching the tag register
	localparam int SETTLE_CYCLES = 8;
	// long receiver hold-off used to back the record up into the parser input
	localparam int HOLD_CYCLES = 300;
	// cycles with no item moving on either side before the run is declared hung
	localparam int QUIET_LIMIT = 3000;
	localparam int MAX_REPORTS = 10;

	// one char of the emitted position record
	typedef struct packed {
		logic [7:0] ch;
		logic [4:0] idx;
		logic       last;
	} pos_char_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [39:0] cfg_wdata;

	nrmc_in_if  rx_if ();
	nrmc_out_if pos_if ();

	nmea_rmc_position_extractor #(
		.LAT_CHARS(LAT),
		.LON_CHARS(LON)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx_if),
		.pos      (pos_if),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Parser mirror: tracks the sentence state byte by byte and queues the
	// record chars that the comma opening the mode field produces.
	// ------------------------------------------------------------------
	logic [39:0]                  tag_model = nrmc_pkg::TAG_RESET;
	logic [nrmc_pkg::PHASE_W-1:0] rmc_phase = nrmc_pkg::PH_HUNT;
	int unsigned                  field_pos = 0;   // byte position inside tag or field
	bit                           tag_miss = 1'b0;
	bit                           in_field = 1'b0; // consuming the bytes after a comma
	logic [7:0]                   lat_chars [LAT] = '{default: 8'h00};
	logic [7:0]                   lon_chars [LON] = '{default: 8'h00};
	logic [7:0]                   ns_flag = 8'h00;
	logic [7:0]                   ew_flag = 8'h00;

	pos_char_t pending_chars [$];

	int  err_cnt = 0;
	int  bytes_sent = 0;
	int  quiet_cycles = 0;
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_req = 1'b0;
	int  hold_left = 0;

	// bytes consumed after the comma that opens each field
	function automatic int unsigned rmc_field_len(input logic [nrmc_pkg::PHASE_W-1:0] ph);
		case (ph)
			nrmc_pkg::PH_TIME:   return 10;
			nrmc_pkg::PH_STATUS: return 1;
			nrmc_pkg::PH_LAT:    return LAT;
			nrmc_pkg::PH_NS:     return 1;
			nrmc_pkg::PH_LON:    return LON;
			nrmc_pkg::PH_EW:     return 1;
			nrmc_pkg::PH_SPEED:  return 5;
			nrmc_pkg::PH_COURSE: return 7;
			nrmc_pkg::PH_DATE:   return 6;
			nrmc_pkg::PH_MAGDIR: return 1;
			default:             return 0;   // magnetic variation and mode: comma only
		endcase
	endfunction

	task automatic parse_rx_byte(input logic [7:0] b);
		int unsigned len;
		pos_char_t   c;
		len = rmc_field_len(rmc_phase);
		if (rmc_phase == nrmc_pkg::PH_HUNT) begin
			if (b == nrmc_pkg::CHAR_DOLLAR) begin
				rmc_phase = nrmc_pkg::PH_TAG;
				field_pos = 0;
				tag_miss = 1'b0;
			end
		end else if (rmc_phase == nrmc_pkg::PH_TAG) begin
			// a dollar here is just another tag byte, compared against the live register
			if (b != tag_model[8 * (4 - field_pos) +: 8])
				tag_miss = 1'b1;
			field_pos++;
			if (field_pos >= 5) begin
				rmc_phase = tag_miss ? nrmc_pkg::PH_HUNT : nrmc_pkg::PH_TIME;
				field_pos = 0;
				in_field = 1'b0;
				tag_miss = 1'b0;
			end
		end else if (!in_field) begin
			// between fields only a comma matters
			if (b == nrmc_pkg::CHAR_COMMA) begin
				if (rmc_phase == nrmc_pkg::PH_MODE) begin
					for (int k = 0; k < RECORD_CHARS; k++) begin
						if (k == 0)
							c.ch = ns_flag;
						else if (k <= LAT)
							c.ch = lat_chars[k - 1];
						else if (k == LAT + 1)
							c.ch = ew_flag;
						else
							c.ch = lon_chars[k - LAT - 2];
						c.idx = k[4:0];
						c.last = (k == RECORD_CHARS - 1);
						pending_chars.push_back(c);
					end
					rmc_phase = nrmc_pkg::PH_HUNT;
					field_pos = 0;
				end else begin
					field_pos = 0;
					if (len == 0)
						rmc_phase++;
					else
						in_field = 1'b1;
				end
			end
		end else begin
			// consuming: commas included, kept fields are captured
			case (rmc_phase)
				nrmc_pkg::PH_LAT: if (field_pos < LAT) lat_chars[field_pos] = b;
				nrmc_pkg::PH_NS:  ns_flag = b;
				nrmc_pkg::PH_LON: if (field_pos < LON) lon_chars[field_pos] = b;
				nrmc_pkg::PH_EW:  ew_flag = b;
				default: ;
			endcase
			field_pos++;
			if (field_pos >= len) begin
				in_field = 1'b0;
				field_pos = 0;
				rmc_phase++;
			end
		end
	endtask

	task automatic check_pos_char();
		pos_char_t got;
		pos_char_t want;
		got = {pos_if.out_char, pos_if.char_index, pos_if.last_char};
		if (pending_chars.size() == 0) begin
			err_cnt++;
			if (err_cnt <= MAX_REPORTS)
				$display("%0t: unexpected record item char %h idx %0d last %b",
					$realtime, got.ch, got.idx, got.last);
		end else begin
			want = pending_chars.pop_front();
			if (got !== want) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display({"%0t: record mismatch: expected char %h idx %0d last %b, ",
						"got char %h idx %0d last %b"}, $realtime, want.ch, want.idx,
						want.last, got.ch, got.idx, got.last);
			end
		end
	endtask

	// both handshakes sampled at the rising edge, before the block updates
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_if.valid && rx_if.ready)
				parse_rx_byte(rx_if.rx_byte);
			if (pos_if.valid && pos_if.ready)
				check_pos_char();
		end
	end

	// hang detector: counts cycles where no item moves on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_if.valid && rx_if.ready) || (pos_if.valid && pos_if.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("%0t: no item moved for %0d cycles", $realtime, quiet_cycles);
					$display("*** FAILED ***");
					$finish;
				end
			end
		end
	end

	// record receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pos_if.ready <= 1'b0;
		end else begin
			pos_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Byte sender and sentence builder. All tasks enter and leave at a
	// falling edge; valid stays high across back-to-back items.
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(negedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready)
			@(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	function automatic logic [7:0] pick_non_comma();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == nrmc_pkg::CHAR_COMMA);
		return b;
	endfunction

	// special content walks through 00, FF, comma and dollar between random bytes
	function automatic logic [7:0] field_byte(input bit special, input int k);
		if (special) begin
			case (k % 5)
				0: return 8'h00;
				1: return 8'hFF;
				2: return nrmc_pkg::CHAR_COMMA;
				3: return nrmc_pkg::CHAR_DOLLAR;
				default: ;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// Builds one RMC sentence with the given tag and sends bytes [from, upto);
	// upto of 0 sends to the end. Junk before a comma is ignored by the parser.
	task automatic send_rmc(input logic [39:0] tag, input int junk_pct, input int from,
		input int upto, input bit special);
		logic [7:0]                   seq [$];
		logic [nrmc_pkg::PHASE_W-1:0] ph;
		int                           stop;
		seq.push_back(nrmc_pkg::CHAR_DOLLAR);
		for (int i = 0; i < 5; i++)
			seq.push_back(tag[8 * (4 - i) +: 8]);
		for (ph = nrmc_pkg::PH_TIME; ph <= nrmc_pkg::PH_MODE; ph++) begin
			if ($urandom_range(99) < junk_pct)
				repeat ($urandom_range(1, 3)) seq.push_back(pick_non_comma());
			seq.push_back(nrmc_pkg::CHAR_COMMA);
			for (int k = 0; k < rmc_field_len(ph); k++)
				seq.push_back(field_byte(special, k));
		end
		stop = (upto == 0 || upto > seq.size()) ? seq.size() : upto;
		for (int i = from; i < stop; i++)
			send_byte(seq[i]);
	endtask

	// drop valid and let the record drain before the next phase
	task automatic wait_drained();
		rx_if.valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_tag(input logic [39:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		tag_model = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset tag, commas and dollars inside consumed fields, 00/FF captures, junk
	task automatic test_default_sentence();
		send_idle_pct = 34;
		recv_stall_pct = 69;
		send_rmc(nrmc_pkg::TAG_RESET, 20, 0, 0, 1'b1);
		wait_drained();
	endtask

	// wrong last tag byte; a second dollar eaten as a tag byte
	task automatic test_tag_mismatch();
		send_text("$GNRMX,");
		send_text("$$GNRMC,");
		wait_drained();
	endtask

	// dollars as tag bytes, and the tag register changed halfway through a tag
	task automatic test_tag_change_midway();
		logic [39:0] good;
		good = nrmc_pkg::TAG_RESET;
		send_idle_pct = 69;
		recv_stall_pct = 34;
		set_tag(40'h2424242424);
		send_rmc({32'h24242424, 8'h24}, 0, 0, 4, 1'b0);
		wait_drained();
		set_tag(good);
		send_rmc({24'h242424, good[15:0]}, 0, 4, 0, 1'b0);
		wait_drained();
	endtask

	// receiver holds off while the sender keeps offering bytes past a record
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		hold_req = 1'b1;
		@(negedge clk);
		send_rmc(nrmc_pkg::TAG_RESET, 0, 0, 0, 1'b0);
		send_rmc(nrmc_pkg::TAG_RESET, 0, 0, 3, 1'b0);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = 8'h00;
		pos_if.ready = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_default_sentence();
		test_tag_mismatch();
		test_tag_change_midway();
		test_backpressure();

		if (err_cnt == 0 && pending_chars.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
